@@ src/mm2a_pkg.sv @@
package mm2a_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [2:0]  FULL_BYTES  = 3'd4;

    typedef enum logic [1:0] {
        KIND_BODY,
        KIND_LAST_FULL,
        KIND_LAST_PART
    } mm2a_kind_t;

    // One classified word on its way from the front end to the mixer
    typedef struct packed {
        logic [31:0] k;
        mm2a_kind_t  kind;
        logic [2:0]  incr;
    } mm2a_item_t;

endpackage

@@ src/mm2a_front.sv @@
module mm2a_front
    import mm2a_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_last_item,
    output logic        push_valid,
    input  logic        push_ready,
    output mm2a_item_t  push_item
);

    logic [2:0]  nbytes;
    logic [31:0] tail_mask;

    always_comb begin
        // clamp byte counts above a full word
        if (s_valid_bytes inside {[3'd4:3'd7]}) begin
            nbytes = FULL_BYTES;
        end else begin
            nbytes = s_valid_bytes;
        end

        case (nbytes[1:0])
            2'd0:    tail_mask = 32'h0000_0000;
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase

        if (!s_last_item) begin
            push_item.kind = KIND_BODY;
            push_item.incr = FULL_BYTES;
            push_item.k    = s_data_word;
        end else if (nbytes == FULL_BYTES) begin
            push_item.kind = KIND_LAST_FULL;
            push_item.incr = FULL_BYTES;
            push_item.k    = s_data_word;
        end else begin
            push_item.kind = KIND_LAST_PART;
            push_item.incr = nbytes;
            push_item.k    = s_data_word & tail_mask;
        end
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

@@ src/mm2a_fifo.sv @@
module mm2a_fifo
    import mm2a_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  mm2a_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output mm2a_item_t out_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mm2a_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_pointer_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

    a_full_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CNT_W'(DEPTH)) |-> !in_ready)
        else $error("full queue still ready");
`endif

endmodule

@@ src/mm2a_back.sv @@
module mm2a_back
    import mm2a_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  mm2a_item_t  item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_H,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_BODY,
        PH_WORD,
        PH_TAIL,
        PH_LEN
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] seed_reg, seed_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] total_reg, total_next;
    logic        mid_reg, mid_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] mul_a;
    logic [31:0] prod;

    // single shared multiplier, low word only
    assign prod = mul_a * MIX_MUL;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        seed_next    = cfg_wr_en ? cfg_wr_data : seed_reg;
        h_next       = h_reg;
        k_next       = k_reg;
        total_next   = total_reg;
        mid_next     = mid_reg;
        m_valid_next = m_valid_reg && !m_ready;
        hash_next    = hash_reg;
        item_ready   = 1'b0;
        mul_a        = k_reg;

        case (state_reg)
            ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    // first word of a message starts from the seed
                    h_next     = mid_reg ? h_reg : seed_reg;
                    k_next     = item.k;
                    total_next = total_reg + 32'(item.incr);
                    state_next = ST_K1;
                    case (item.kind)
                        KIND_BODY:      phase_next = PH_BODY;
                        KIND_LAST_FULL: phase_next = PH_WORD;
                        KIND_LAST_PART: phase_next = PH_TAIL;
                        default:        phase_next = PH_BODY;
                    endcase
                end
            end
            ST_K1: begin
                mul_a      = k_reg;
                k_next     = prod;
                state_next = ST_K2;
            end
            ST_K2: begin
                mul_a      = k_reg ^ (k_reg >> MIX_SHIFT);
                k_next     = prod;
                state_next = ST_H;
            end
            ST_H: begin
                mul_a  = h_reg;
                h_next = prod ^ k_reg;
                case (phase_reg)
                    PH_BODY: begin
                        mid_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    PH_WORD: begin
                        k_next     = '0;
                        phase_next = PH_TAIL;
                        state_next = ST_K1;
                    end
                    PH_TAIL: begin
                        k_next     = total_reg;
                        phase_next = PH_LEN;
                        state_next = ST_K1;
                    end
                    PH_LEN: begin
                        state_next = ST_FIN;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FIN: begin
                mul_a = h_reg ^ (h_reg >> FIN_SHIFT_A);
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    hash_next    = prod ^ (prod >> FIN_SHIFT_B);
                    m_valid_next = 1'b1;
                    mid_next     = 1'b0;
                    total_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_BODY;
            seed_reg    <= '0;
            total_reg   <= '0;
            mid_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            seed_reg    <= seed_next;
            total_reg   <= total_next;
            mid_reg     <= mid_next;
            m_valid_reg <= m_valid_next;
        end
        h_reg    <= h_next;
        k_reg    <= k_next;
        hash_reg <= hash_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = hash_reg;

`ifndef SYNTHESIS
    a_len_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_H && phase_reg == PH_LEN) |=> (state_reg == ST_FIN))
        else $error("length mix not followed by finalization");

    a_fin_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && (!m_valid_reg || m_ready))
        |=> (m_valid_reg && !mid_reg && total_reg == '0 && state_reg == ST_IDLE))
        else $error("finalization did not emit and clear message state");

    a_body_sets_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_H && phase_reg == PH_BODY) |=> (mid_reg && state_reg == ST_IDLE))
        else $error("body word did not mark the message as open");
`endif

endmodule

@@ src/murmur2a_stream_hash.sv @@
// Result: a last word with 0..3 bytes is masked and mixed as the tail; a last word with
// 4 bytes is mixed whole, then a zero tail; the byte total is mixed last, and the hash
// waits for a free output. Body words go through K1, K2 and H on the one shared 32x32
// multiplier (three multiplies per word), one word at a time; the queue absorbs short bursts.
// Reset: synchronous, active low; seed clears to 0, the queue empties, no result pending.
module murmur2a_stream_hash
    import mm2a_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_last_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    logic       push_valid, push_ready;
    mm2a_item_t push_item;
    logic       pop_valid, pop_ready;
    mm2a_item_t pop_item;

    mm2a_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_valid_bytes (s_valid_bytes),
        .s_last_item   (s_last_item),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    mm2a_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_item  (pop_item)
    );

    mm2a_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (pop_valid),
        .item_ready   (pop_ready),
        .item         (pop_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule

@@ tb/murmur2a_stream_hash_tb.sv @@
`timescale 1ns / 1ps

module murmur2a_stream_hash_tb;

    localparam logic [31:0] HASH_MUL        = 32'h5bd1e995;
    localparam int          K_SHIFT         = 24;
    localparam int          FINAL_SHIFT_A   = 13;
    localparam int          FINAL_SHIFT_B   = 15;
    localparam int          DRAIN_CYCLES    = 40;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          WATCHDOG_LIMIT  = 4000;
    localparam int          NUM_PHASES      = 8;
    localparam int          PRESSURE_PHASE  = 3;
    localparam int          WORDS_PER_PHASE = 225;
    localparam int          NUM_ROWS        = 21;

    typedef enum logic {
        ROW_WORD,
        ROW_SEED
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
        logic        pinned;
        logic [31:0] pinned_hash;
    } stim_row_t;

    // Seed rows carry the seed value in the data field
    stim_row_t stim_rows [NUM_ROWS] = '{
        '{ROW_SEED, 32'h0000_0000, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0},
        '{ROW_WORD, 32'hffff_ffff, 3'd0, 1'b1, 1'b1, 32'h0},
        '{ROW_WORD, 32'hffff_ffff, 3'd1, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'h1234_5678, 3'd2, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'hffff_ffff, 3'd3, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'hffff_ffff, 3'd4, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'hdead_beef, 3'd7, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0000, 3'd5, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'hffff_ffff, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'ha5a5_a5a5, 3'd7, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0bad_f00d, 3'd3, 1'b1, 1'b0, 32'h0},
        '{ROW_SEED, 32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0001, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h8000_0000, 3'd4, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'h1111_1111, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_SEED, 32'h1234_5678, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'hcafe_0042, 3'd2, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'h5a5a_5a5a, 3'd1, 1'b1, 1'b0, 32'h0}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data_word;
    logic [2:0]  s_valid_bytes;
    logic        s_last_item;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_hash_value;

    // Hash model state
    logic [31:0] seed_reg;
    logic [31:0] run_hash;
    logic [31:0] byte_count;
    logic        in_message;

    logic [31:0] pending_hashes[$];
    logic [31:0] hash_head;
    int          mismatch_count;
    int          words_sent;
    int          stall_cycles;
    logic        idling_on;
    logic        hold_off_req;

    murmur2a_stream_hash i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_valid_bytes (s_valid_bytes),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hash_value  (m_hash_value)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [31:0] mix_block(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] m;
        m = k * HASH_MUL;
        m = m ^ (m >> K_SHIFT);
        m = m * HASH_MUL;
        return (h * HASH_MUL) ^ m;
    endfunction

    // Advance the hash state by one word; return 1 with the final hash on a last word
    function automatic logic absorb_word(input logic [31:0] data, input logic [2:0] nbytes,
                                         input logic last, output logic [31:0] hash);
        logic [31:0] h;
        logic [31:0] tail;
        logic [2:0]  n;
        h    = run_hash;
        tail = 32'h0;
        n    = nbytes;
        hash = 32'h0;
        if (!last) begin
            run_hash   = mix_block(h, data);
            byte_count = byte_count + 32'd4;
            in_message = 1'b1;
            return 1'b0;
        end
        if (n > 3'd4) begin
            n = 3'd4;
        end
        if (n == 3'd4) begin
            h = mix_block(h, data);
        end else begin
            tail = data & ((32'h1 << (8 * n)) - 32'h1);
        end
        byte_count = byte_count + {29'h0, n};
        h = mix_block(h, tail);
        h = mix_block(h, byte_count);
        h = h ^ (h >> FINAL_SHIFT_A);
        h = h * HASH_MUL;
        h = h ^ (h >> FINAL_SHIFT_B);
        hash       = h;
        run_hash   = seed_reg;
        byte_count = 32'h0;
        in_message = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 7))
            0: begin
                return 32'h0;
            end
            1: begin
                return 32'hffff_ffff;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                             input logic last, input logic pinned,
                             input logic [31:0] pinned_hash);
        logic [31:0] hash;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_word   <= data;
        s_valid_bytes <= nbytes;
        s_last_item   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (absorb_word(data, nbytes, last, hash)) begin
            pending_hashes.insert(pending_hashes.size(), pinned ? pinned_hash : hash);
        end
    endtask

    task automatic send_message(input logic short_only);
        int body_len;
        if (short_only) begin
            body_len = $urandom_range(0, 2);
        end else begin
            case ($urandom_range(0, 9))
                7, 8: begin
                    body_len = $urandom_range(4, 12);
                end
                9: begin
                    body_len = $urandom_range(13, 40);
                end
                default: begin
                    body_len = $urandom_range(0, 3);
                end
            endcase
        end
        // Mostly well-formed words; now and then a body word with a bad byte count
        for (int i = 0; i < body_len; i++) begin
            send_word(pick_data(),
                      ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                      1'b0, 1'b0, 32'h0);
        end
        send_word(pick_data(),
                  ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4)),
                  1'b1, 1'b0, 32'h0);
    endtask

    // Drop valid, wait for every hash, then let in-flight body words settle
    task automatic drain_block();
        s_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        seed_reg = value;
        if (!in_message) begin
            run_hash = value;
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected hash %08h, expected none", $time, m_hash_value);
                mismatch_count++;
            end else begin
                hash_head = pending_hashes.pop_front();
                if (m_hash_value !== hash_head) begin
                    $display("%0t: hash mismatch: expected %08h, actual %08h",
                             $time, hash_head, m_hash_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d hashes outstanding",
                     $time, pending_hashes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [31:0] phase_seed;
        int          target;
        seed_reg       = 32'h0;
        run_hash       = 32'h0;
        byte_count     = 32'h0;
        in_message     = 1'b0;
        mismatch_count = 0;
        words_sent     = 0;
        stall_cycles   = 0;
        idling_on      = 1'b1;
        hold_off_req   = 1'b0;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 32'h0;
        s_valid       <= 1'b0;
        s_data_word   <= 32'h0;
        s_valid_bytes <= 3'd0;
        s_last_item   <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_SEED) begin
                drain_block();
                write_seed(stim_rows[r].data);
            end else begin
                send_word(stim_rows[r].data, stim_rows[r].nbytes, stim_rows[r].last,
                          stim_rows[r].pinned, stim_rows[r].pinned_hash);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_block();
            case (p)
                0: begin
                    phase_seed = 32'h0;
                end
                1: begin
                    phase_seed = 32'hffff_ffff;
                end
                2: begin
                    phase_seed = 32'h8000_0000;
                end
                3: begin
                    phase_seed = 32'h0000_0001;
                end
                default: begin
                    phase_seed = $urandom;
                end
            endcase
            write_seed(phase_seed);
            if (p == NUM_PHASES - 1) begin
                idling_on = 1'b0;
            end
            if (p == PRESSURE_PHASE) begin
                hold_off_req = 1'b1;
            end
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target) send_message(p == PRESSURE_PHASE);
        end

        drain_block();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
